@@ hdl/debounced_button_bcd_counter_assert.svh @@
// assertion macros used by the counter rtl
`ifndef DEBOUNCED_BUTTON_BCD_COUNTER_ASSERT_SVH
`define DEBOUNCED_BUTTON_BCD_COUNTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define DBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dbc_pkg.sv @@
// types, constants and segment decode for the debounced bcd counter
package dbc_pkg;

  localparam int LEVELS_W        = 8;
  localparam int HIST_W          = 16;
  localparam int TOTAL_W         = 14;
  localparam int SEG_W           = 8;
  localparam int NUM_DIGITS      = 4;
  localparam int SHIFTS_PER_SCAN = 6;

  localparam logic [HIST_W-1:0]  HIST_FORCE = 16'hE000;
  localparam logic [HIST_W-1:0]  HIST_FIRE  = 16'hF000;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL  = 14'd9999;
  localparam logic [TOTAL_W-1:0] LIMIT_RST  = 14'd1023;
  localparam logic [SEG_W-1:0]   SEG_BLANK  = 8'hFF;

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [NUM_DIGITS-1:0] bcd_word_t;

  localparam bcd_digit_t DIGIT_MAX = 4'd9;
  localparam bcd_digit_t DIGIT_TEN = 4'd10;

  function automatic logic [SEG_W-1:0] seg_code(bcd_digit_t d);
    logic [SEG_W-1:0] code;
    case (d)
      4'd0:    code = 8'b11000000;
      4'd1:    code = 8'b11111001;
      4'd2:    code = 8'b10100100;
      4'd3:    code = 8'b10110000;
      4'd4:    code = 8'b10011001;
      4'd5:    code = 8'b10010010;
      4'd6:    code = 8'b10000010;
      4'd7:    code = 8'b11111000;
      4'd8:    code = 8'b10000000;
      4'd9:    code = 8'b10010000;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  // power-of-two increment to bcd
  function automatic bcd_word_t incr_to_bcd(logic [LEVELS_W-1:0] incr);
    bcd_word_t w;
    case (incr)
      8'd1:    w = {4'd0, 4'd0, 4'd0, 4'd1};
      8'd2:    w = {4'd0, 4'd0, 4'd0, 4'd2};
      8'd4:    w = {4'd0, 4'd0, 4'd0, 4'd4};
      8'd8:    w = {4'd0, 4'd0, 4'd0, 4'd8};
      8'd16:   w = {4'd0, 4'd0, 4'd1, 4'd6};
      8'd32:   w = {4'd0, 4'd0, 4'd3, 4'd2};
      8'd64:   w = {4'd0, 4'd0, 4'd6, 4'd4};
      8'd128:  w = {4'd0, 4'd1, 4'd2, 4'd8};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/dbc_debounce.sv @@
// per-button debounce histories and press detection
module dbc_debounce #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dbc_pkg::LEVELS_W-1:0] levels,
  input  logic                         step,
  output logic [dbc_pkg::LEVELS_W-1:0] incr
);
  import dbc_pkg::*;

  logic [HIST_W-1:0]      history      [NUM_BUTTONS];
  logic [HIST_W-1:0]      history_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] fired;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    always_comb begin
      history_next[b] = history[b];
      fired[b]        = 1'b0;
      for (int s = 0; s < SHIFTS_PER_SCAN; s++) begin
        history_next[b] = {history_next[b][HIST_W-2:0], levels[b]} | HIST_FORCE;
        if (history_next[b] == HIST_FIRE) begin
          fired[b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        history[b] <= '0;
      end else if (step) begin
        history[b] <= history_next[b];
      end
    end
  end

  // highest-numbered press wins
  always_comb begin
    incr = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (fired[b]) begin
        incr    = '0;
        incr[b] = 1'b1;
      end
    end
  end

endmodule

@@ hdl/debounced_button_bcd_counter.sv @@
// top level: debounced button scans drive a bcd counter with seven-segment output
//
// Input channel: one beat per scan of eight active-low buttons (bit low means
// pressed), handshaken by in_valid/in_ready. Each scan debounces every button,
// adds 2^index of the highest button that fired to a four-digit bcd total and
// rolls the total over to one when it passes the limit.
// Output channel: one beat per scan on out_valid/out_ready, carrying four
// active-low segment codes (upper zero digits blank until a carry reaches them)
// and the binary total.
// The output beat is registered and valid in the cycle after its input beat;
// one scan is taken every cycle unless the receiver stalls. The whole scan is
// one pass of logic between the state/input and the output register.
// The output register holds a beat while out_ready is low; in_ready is high
// whenever that register is empty or being drained, so a stalled receiver
// stops intake only once the output register is full.
// cfg_we writes count_limit (values above 9999 act as 9999); the user must
// write it only while idle, as the block does not enforce this. Reset clears
// histories, digits, blanking flags and total to zero and sets the limit to 1023.
`include "debounced_button_bcd_counter_assert.svh"

module debounced_button_bcd_counter #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dbc_pkg::LEVELS_W-1:0] button_levels,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dbc_pkg::SEG_W-1:0]    seg_digit0,
  output logic [dbc_pkg::SEG_W-1:0]    seg_digit1,
  output logic [dbc_pkg::SEG_W-1:0]    seg_digit2,
  output logic [dbc_pkg::SEG_W-1:0]    seg_digit3,
  output logic [dbc_pkg::TOTAL_W-1:0]  count_value,
  input  logic                         cfg_we,
  input  logic [dbc_pkg::TOTAL_W-1:0]  cfg_wdata
);
  import dbc_pkg::*;

  logic [TOTAL_W-1:0]    count_limit;
  logic [TOTAL_W-1:0]    total;
  bcd_word_t             digits;
  logic [NUM_DIGITS-2:0] shown;

  logic                  accept;
  logic [LEVELS_W-1:0]   incr;
  logic [TOTAL_W-1:0]    limit_eff;
  logic [TOTAL_W-1:0]    sum;
  logic                  rollover;
  bcd_word_t             incr_bcd;
  bcd_word_t             digits_add;
  logic [NUM_DIGITS:0]   carry;
  logic [4:0]            dsum;
  logic [TOTAL_W-1:0]    total_next;
  bcd_word_t             digits_next;
  logic [NUM_DIGITS-2:0] shown_next;
  logic [SEG_W-1:0]      seg_next [NUM_DIGITS];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  dbc_debounce #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_debounce (
    .clk    (clk),
    .rst    (rst),
    .levels (button_levels),
    .step   (accept),
    .incr   (incr)
  );

  assign limit_eff = (count_limit > MAX_TOTAL) ? MAX_TOTAL : count_limit;
  assign sum       = total + TOTAL_W'(incr);
  assign rollover  = sum > limit_eff;
  assign incr_bcd  = incr_to_bcd(incr);

  // bcd ripple add
  always_comb begin
    carry[0] = 1'b0;
    dsum     = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      dsum = {1'b0, digits[k]} + {1'b0, incr_bcd[k]} + {4'd0, carry[k]};
      if (dsum > {1'b0, DIGIT_MAX}) begin
        digits_add[k] = 4'(dsum - {1'b0, DIGIT_TEN});
        carry[k+1]    = 1'b1;
      end else begin
        digits_add[k] = dsum[3:0];
        carry[k+1]    = 1'b0;
      end
    end
  end

  always_comb begin
    if (rollover) begin
      total_next  = TOTAL_W'(1);
      digits_next = {4'd0, 4'd0, 4'd0, 4'd1};
      shown_next  = '0;
    end else begin
      total_next  = sum;
      digits_next = digits_add;
      shown_next  = shown | carry[NUM_DIGITS-1:1];
    end
  end

  always_comb begin
    seg_next[0] = seg_code(digits_next[0]);
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if (digits_next[k] == 4'd0 && !shown_next[k-1]) begin
        seg_next[k] = SEG_BLANK;
      end else begin
        seg_next[k] = seg_code(digits_next[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      count_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      digits <= '0;
      shown  <= '0;
    end else if (accept) begin
      total  <= total_next;
      digits <= digits_next;
      shown  <= shown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      seg_digit0  <= seg_next[0];
      seg_digit1  <= seg_next[1];
      seg_digit2  <= seg_next[2];
      seg_digit3  <= seg_next[3];
      count_value <= total_next;
    end
  end

  `DBC_ASSERT_NOW(a_total_range, out_valid, count_value <= MAX_TOTAL, "total above 9999")
  `DBC_ASSERT_NOW(a_digits_track_total, 1'b1,
    total == 14'(digits[3]) * 14'd1000 + 14'(digits[2]) * 14'd100
      + 14'(digits[1]) * 14'd10 + 14'(digits[0]),
    "bcd digits disagree with total")
  `DBC_ASSERT_NOW(a_units_not_blank, out_valid, seg_digit0 != SEG_BLANK, "units digit blanked")
  `DBC_ASSERT_NEXT(a_accept_gives_beat, accept, out_valid && count_value == total,
    "accepted scan gave no matching output beat")
  `DBC_ASSERT_NOW(a_full_blocks_intake, out_valid && !out_ready, !in_ready,
    "scan taken while output register full")
  `DBC_ASSERT_NOW(a_no_top_carry, !rollover, !carry[NUM_DIGITS],
    "carry out of thousands digit")

endmodule

@@ tb/debounced_button_bcd_counter_tb.sv @@
// self-checking testbench for the debounced button bcd counter with random handshake stalls
module debounced_button_bcd_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbc_pkg::*;

  localparam int BUTTONS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DIRECTED_LEN = 23;

  localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam logic [LEVELS_W-1:0] DIRECTED_SCANS [DIRECTED_LEN] = '{
    8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
    8'hFE, 8'hFE, 8'hFF, 8'h7F, 8'h7F, 8'hFF, 8'hFE, 8'hFF,
    8'hFE, 8'hFE, 8'hFF, 8'hAA, 8'hAA, 8'h55, 8'h55
  };

  typedef enum int {SCAN_DIRECTED, SCAN_WALK, SCAN_COUNT_RUN} scan_mix_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][SEG_W-1:0] seg;
    logic [TOTAL_W-1:0]               total;
  } display_t;

  class display_scoreboard;
    logic [HIST_W-1:0]  history [BUTTONS];
    bcd_digit_t         digits [NUM_DIGITS];
    bit                 carried [NUM_DIGITS-1];
    int unsigned        total;
    logic [TOTAL_W-1:0] limit;
    display_t           pending_displays [$];
    int unsigned        fail_count;

    function new();
      foreach (history[b]) history[b] = '0;
      foreach (digits[k]) digits[k] = '0;
      foreach (carried[k]) carried[k] = 1'b0;
      total = 0;
      limit = LIMIT_RST;
      fail_count = 0;
    endfunction

    function void set_limit(logic [TOTAL_W-1:0] value);
      limit = value;
    endfunction

    function logic [SEG_W-1:0] segments_for(bcd_digit_t d);
      return (d <= DIGIT_MAX) ? SEG_TABLE[d] : SEG_BLANK;
    endfunction

    function void note_scan(logic [LEVELS_W-1:0] levels);
      logic [HIST_W-1:0] h;
      bit                fired;
      int unsigned       incr;
      int unsigned       lim;
      int unsigned       sum;
      int unsigned       d [NUM_DIGITS];
      int                b;
      int                s;
      int                k;
      display_t          e;
      incr = 0;
      lim = (limit > MAX_TOTAL) ? int'(MAX_TOTAL) : int'(limit);
      for (b = 0; b < BUTTONS; b++) begin
        h = history[b];
        fired = 1'b0;
        for (s = 0; s < SHIFTS_PER_SCAN; s++) begin
          h = (h << 1) | HIST_W'(levels[b]) | HIST_FORCE;
          if (h == HIST_FIRE) fired = 1'b1;
        end
        history[b] = h;
        if (fired) incr = 1 << b;
      end
      sum = total + incr;
      if (sum > lim) begin
        total = 1;
        digits[0] = 4'd1;
        for (k = 1; k < NUM_DIGITS; k++) digits[k] = 4'd0;
        foreach (carried[j]) carried[j] = 1'b0;
      end else begin
        total = sum;
        for (k = 0; k < NUM_DIGITS; k++) d[k] = digits[k];
        d[0] += incr;
        for (k = 0; k < NUM_DIGITS - 1; k++) begin
          while (d[k] > 9) begin
            d[k] -= 10;
            d[k+1] += 1;
            carried[k] = 1'b1;
          end
        end
        for (k = 0; k < NUM_DIGITS; k++) digits[k] = d[k][3:0];
      end
      e.seg[0] = segments_for(digits[0]);
      for (k = 1; k < NUM_DIGITS; k++) begin
        if (digits[k] == 4'd0 && !carried[k-1]) e.seg[k] = SEG_BLANK;
        else e.seg[k] = segments_for(digits[k]);
      end
      e.total = total[TOTAL_W-1:0];
      pending_displays.push_back(e);
    endfunction

    function void check_display(logic [NUM_DIGITS-1:0][SEG_W-1:0] seg,
                                logic [TOTAL_W-1:0] count);
      display_t e;
      int       k;
      if (pending_displays.size() == 0) begin
        $error("output beat with nothing expected: count_value %0d", count);
        fail_count++;
        return;
      end
      e = pending_displays.pop_front();
      for (k = 0; k < NUM_DIGITS; k++) begin
        if (seg[k] !== e.seg[k]) begin
          $error("seg_digit%0d: expected %h, actual %h", k, e.seg[k], seg[k]);
          fail_count++;
        end
      end
      if (count !== e.total) begin
        $error("count_value: expected %0d, actual %0d", e.total, count);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [LEVELS_W-1:0] button_levels = '1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SEG_W-1:0]    seg_digit0;
  logic [SEG_W-1:0]    seg_digit1;
  logic [SEG_W-1:0]    seg_digit2;
  logic [SEG_W-1:0]    seg_digit3;
  logic [TOTAL_W-1:0]  count_value;
  logic                cfg_we = 1'b0;
  logic [TOTAL_W-1:0]  cfg_wdata = '0;

  display_scoreboard   sb = new();
  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  bit                  hold_req = 1'b0;
  logic [LEVELS_W-1:0] walk_levels = '1;

  debounced_button_bcd_counter #(
    .NUM_BUTTONS(BUTTONS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_levels(button_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_digit0   (seg_digit0),
    .seg_digit1   (seg_digit1),
    .seg_digit2   (seg_digit2),
    .seg_digit3   (seg_digit3),
    .count_value  (count_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_scan(button_levels);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_display({seg_digit3, seg_digit2, seg_digit1, seg_digit0}, count_value);
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("debounced_button_bcd_counter test failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_scan(input logic [LEVELS_W-1:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    button_levels <= levels;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [TOTAL_W-1:0] value);
    while (sb.pending_displays.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic run_phase(input scan_mix_t mix, input int first, input int count,
                           input int unsigned idle, input int unsigned stall);
    logic [LEVELS_W-1:0] levels;
    int                  i;
    int                  ph;
    send_idle_pct = idle;
    stall_pct = stall;
    for (i = 0; i < count; i++) begin
      case (mix)
        SCAN_DIRECTED: begin
          levels = DIRECTED_SCANS[first + i];
        end
        SCAN_WALK: begin
          // buttons mostly hold their level so press sequences form
          walk_levels = walk_levels ^ LEVELS_W'($urandom & $urandom);
          levels = ($urandom_range(99) < 80) ? walk_levels : LEVELS_W'($urandom);
        end
        default: begin
          // top three buttons fire in turn, one per scan
          ph = i % 3;
          levels = LEVELS_W'($urandom);
          levels[7] = (ph == 0);
          levels[6] = (ph == 1);
          levels[5] = (ph == 2);
          if (i == 50) hold_req = 1'b1;
        end
      endcase
      send_scan(levels);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    write_limit(14'd0);
    run_phase(SCAN_DIRECTED, 0, 4, 0, 0);
    write_limit(LIMIT_RST);
    run_phase(SCAN_DIRECTED, 4, DIRECTED_LEN - 4, 0, 0);

    write_limit(14'd1);
    run_phase(SCAN_WALK, 0, 40, 77, 0);
    write_limit(14'd0);
    run_phase(SCAN_WALK, 0, 30, 0, 77);
    write_limit(14'd16383);
    run_phase(SCAN_COUNT_RUN, 0, 150, 0, 0);
    write_limit(14'd10000);
    run_phase(SCAN_WALK, 0, 40, 35, 35);
    write_limit(14'd99);
    run_phase(SCAN_WALK, 0, 60, 77, 0);
    write_limit(TOTAL_W'($urandom_range(2, 9998)));
    run_phase(SCAN_WALK, 0, 60, 35, 35);
    write_limit(MAX_TOTAL);
    run_phase(SCAN_WALK, 0, 60, 0, 77);

    while (sb.pending_displays.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (sb.fail_count == 0)
      $display("debounced_button_bcd_counter test passed");
    else
      $display("debounced_button_bcd_counter test failed");
    $finish;
  end

endmodule

@@ debounced_button_bcd_counter.f @@
+incdir+hdl
hdl/dbc_pkg.sv
hdl/dbc_debounce.sv
hdl/debounced_button_bcd_counter.sv
tb/debounced_button_bcd_counter_tb.sv
